FILE: rtl/dd_odo_pkg.sv
`timescale 1ns / 1ps
package dd_odo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ITER_W = $clog2(CORDIC_STEPS);
	localparam int ATAN_IDX_W = 5;
	localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STEPS - 1);

	localparam int CORD_W = 34;
	localparam int ANG_W = 36;
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 26;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	localparam logic signed [ANG_W-1:0] PI_Q = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q = 36'sd843314857;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [15:0] RADIUS_RESET = 16'd6554;
	localparam logic [15:0] SCALE_RESET = 16'd3523;

	typedef enum logic {
		REG_WHEEL_RADIUS = 1'b0,
		REG_TURN_SCALE   = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VLIN,
		ST_VANG,
		ST_DIST,
		ST_TURN,
		ST_MID,
		ST_FOLD,
		ST_WRAP,
		ST_ANG,
		ST_CORD,
		ST_CS,
		ST_MX,
		ST_MY,
		ST_WB
	} state_t;

	// atan(2^-i), Q2.30
	function automatic logic signed [CORD_W-1:0] atan_q(input logic [ATAN_IDX_W-1:0] idx);
		case (idx)
			5'd0:  return 34'sd843314857;
			5'd1:  return 34'sd497837829;
			5'd2:  return 34'sd263043837;
			5'd3:  return 34'sd133525159;
			5'd4:  return 34'sd67021687;
			5'd5:  return 34'sd33543516;
			5'd6:  return 34'sd16775851;
			5'd7:  return 34'sd8388437;
			5'd8:  return 34'sd4194283;
			5'd9:  return 34'sd2097149;
			5'd10: return 34'sd1048576;
			5'd11: return 34'sd524288;
			5'd12: return 34'sd262144;
			5'd13: return 34'sd131072;
			5'd14: return 34'sd65536;
			5'd15: return 34'sd32768;
			5'd16: return 34'sd16384;
			5'd17: return 34'sd8192;
			5'd18: return 34'sd4096;
			5'd19: return 34'sd2048;
			5'd20: return 34'sd1024;
			5'd21: return 34'sd512;
			5'd22: return 34'sd256;
			5'd23: return 34'sd128;
			5'd24: return 34'sd64;
			5'd25: return 34'sd32;
			5'd26: return 34'sd16;
			5'd27: return 34'sd8;
			5'd28: return 34'sd4;
			5'd29: return 34'sd2;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [31:0] wrap_once(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		if (a > PI_Q)
			r = a - TWO_PI_Q;
		else if (a < -PI_Q)
			r = a + TWO_PI_Q;
		else
			r = a;
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ANG_W-1:0] a);
		if (a > 36'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (a < -36'sd2147483648)
			return 32'sh8000_0000;
		else
			return a[31:0];
	endfunction

endpackage

FILE: rtl/dd_odo_mul.sv
`timescale 1ns / 1ps
module dd_odo_mul import dd_odo_pkg::*; (
	input  logic                       clk,
	input  logic signed [MUL_A_W-1:0]  a,
	input  logic signed [MUL_B_W-1:0]  b,
	output logic signed [PROD_W-1:0]   p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

FILE: rtl/dd_odo_cordic.sv
`timescale 1ns / 1ps
module dd_odo_cordic import dd_odo_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [CORD_W-1:0]  z0,
	output logic                      done,
	output logic signed [CORD_W-1:0]  x,
	output logic signed [CORD_W-1:0]  y
);

	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic signed [CORD_W-1:0] xs, ys, at;
	logic [ITER_W-1:0] i_q;
	logic busy_q, done_q;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = atan_q(ATAN_IDX_W'(i_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= busy_q && (i_q == CORDIC_LAST);
			if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == CORDIC_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// one micro-rotation per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!z_q[CORD_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;

endmodule

FILE: rtl/diff_drive_odometry_unit.sv
`timescale 1ns / 1ps
// Wheel update: speed and distance products, angle wrap, CORDIC, cos/sin, x/y products, write-back.
// A new item is taken only once the last is written back; the CORDIC loop, one step per cycle,
// and six passes through the shared 35x26 multiplier set the pace.
// Set pose: written to the pose registers when taken, no result.
// Reset: pose cleared to zero, wheel_radius = 6554, turn_scale = 3523, no result pending.
module diff_drive_odometry_unit import dd_odo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [15:0] left_front_speed,
	input  logic signed [15:0] right_front_speed,
	input  logic signed [15:0] left_rear_speed,
	input  logic signed [15:0] right_rear_speed,
	input  logic [15:0]        elapsed_time,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [31:0] new_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_heading,
	output logic signed [31:0] linear_speed,
	output logic signed [31:0] angular_speed
);

	state_t state_q, state_d;

	logic [15:0] radius_q, scale_q;
	logic signed [31:0] pose_x_q, pose_y_q, pose_h_q;

	logic signed [17:0] sum4_q, diff4_q;
	logic [15:0] dt_q;
	logic signed [MUL_A_W-1:0] rs_q, ks_q;
	logic signed [25:0] dist_q;
	logic signed [33:0] turn_q;
	logic signed [ANG_W-1:0] mid_raw_q, head_raw_q;
	logic signed [31:0] mid_q, head_q;
	logic neg_q;
	logic signed [CORD_W-1:0] cos_q, sin_q;
	logic signed [31:0] x_new_q;
	logic signed [31:0] lin_q, ang_q;

	logic out_valid_q;
	logic signed [31:0] ox_q, oy_q, oh_q, vlin_q, vang_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;

	logic cord_start, cord_done;
	logic signed [CORD_W-1:0] cord_x, cord_y, cord_z0;
	logic signed [ANG_W-1:0] fold_a, mid_ext;
	logic fold_neg;

	logic in_take, wb_go;
	logic signed [PROD_W-1:0] turn_sh;
	logic signed [ANG_W-1:0] xsum, ysum;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign wb_go = !out_valid_q || !out_stall;

	dd_odo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	dd_odo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.z0     (cord_z0),
		.done   (cord_done),
		.x      (cord_x),
		.y      (cord_y)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q) inside
			ST_VLIN: begin
				mul_a = MUL_A_W'({1'b0, radius_q});
				mul_b = MUL_B_W'(sum4_q);
			end
			ST_VANG: begin
				mul_a = MUL_A_W'({1'b0, scale_q});
				mul_b = MUL_B_W'(diff4_q);
			end
			ST_DIST: begin
				mul_a = rs_q;
				mul_b = MUL_B_W'({1'b0, dt_q});
			end
			ST_TURN: begin
				mul_a = ks_q;
				mul_b = MUL_B_W'({1'b0, dt_q});
			end
			ST_MX: begin
				mul_a = MUL_A_W'(cos_q);
				mul_b = dist_q;
			end
			ST_MY, ST_WB: begin
				mul_a = MUL_A_W'(sin_q);
				mul_b = dist_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// fold into +-pi/2, CORDIC works on twice the Q3.29 angle
	always_comb begin
		mid_ext = ANG_W'(mid_q);
		fold_neg = 1'b0;
		fold_a = mid_ext;
		if (mid_ext > HALF_PI_Q) begin
			fold_a = mid_ext - PI_Q;
			fold_neg = 1'b1;
		end else if (mid_ext < -HALF_PI_Q) begin
			fold_a = mid_ext + PI_Q;
			fold_neg = 1'b1;
		end
		cord_z0 = CORD_W'(fold_a <<< 1);
		cord_start = (state_q == ST_ANG);
	end

	always_comb begin
		turn_sh = prod >>> 8;
		xsum = ANG_W'(pose_x_q) + ANG_W'(prod >>> 30);
		ysum = ANG_W'(pose_y_q) + ANG_W'(prod >>> 30);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_take && !command) state_d = ST_VLIN;
			ST_VLIN: state_d = ST_VANG;
			ST_VANG: state_d = ST_DIST;
			ST_DIST: state_d = ST_TURN;
			ST_TURN: state_d = ST_MID;
			ST_MID:  state_d = ST_FOLD;
			ST_FOLD: state_d = ST_WRAP;
			ST_WRAP: state_d = ST_ANG;
			ST_ANG:  state_d = ST_CORD;
			ST_CORD: if (cord_done) state_d = ST_CS;
			ST_CS:   state_d = ST_MX;
			ST_MX:   state_d = ST_MY;
			ST_MY:   state_d = ST_WB;
			ST_WB:   if (wb_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WHEEL_RADIUS: radius_q <= cfg_data;
				REG_TURN_SCALE:   scale_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
		end else if (in_take && command) begin
			pose_x_q <= new_x;
			pose_y_q <= new_y;
			pose_h_q <= wrap_once(ANG_W'(new_heading));
		end else if (state_q == ST_WB && wb_go) begin
			pose_x_q <= x_new_q;
			pose_y_q <= sat32(ysum);
			pose_h_q <= head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_WB && wb_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sum4_q  <= 18'(right_front_speed) + 18'(right_rear_speed)
				+ 18'(left_front_speed) + 18'(left_rear_speed);
			diff4_q <= 18'(right_front_speed) + 18'(right_rear_speed)
				- 18'(left_front_speed) - 18'(left_rear_speed);
			dt_q    <= elapsed_time;
		end
		case (state_q)
			ST_VANG: begin
				rs_q  <= prod[MUL_A_W-1:0];
				lin_q <= 32'(prod >>> 10);
			end
			ST_DIST: begin
				ks_q  <= prod[MUL_A_W-1:0];
				ang_q <= 32'(prod >>> 5);
			end
			ST_TURN: dist_q <= 26'(prod >>> 26);
			ST_MID: begin
				if (turn_sh > PROD_W'(TWO_PI_Q))
					turn_q <= 34'(TWO_PI_Q);
				else if (turn_sh < -PROD_W'(TWO_PI_Q))
					turn_q <= -34'(TWO_PI_Q);
				else
					turn_q <= turn_sh[33:0];
			end
			ST_FOLD: begin
				mid_raw_q  <= ANG_W'(turn_q >>> 1) + ANG_W'(pose_h_q);
				head_raw_q <= ANG_W'(turn_q) + ANG_W'(pose_h_q);
			end
			ST_WRAP: begin
				mid_q  <= wrap_once(mid_raw_q);
				head_q <= wrap_once(head_raw_q);
			end
			ST_ANG: neg_q <= fold_neg;
			ST_CS: begin
				cos_q <= neg_q ? -cord_x : cord_x;
				sin_q <= neg_q ? -cord_y : cord_y;
			end
			ST_MY: x_new_q <= sat32(xsum);
			ST_WB: begin
				if (wb_go) begin
					ox_q   <= x_new_q;
					oy_q   <= sat32(ysum);
					oh_q   <= head_q;
					vlin_q <= lin_q;
					vang_q <= ang_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign out_x         = ox_q;
	assign out_y         = oy_q;
	assign out_heading   = oh_q;
	assign linear_speed  = vlin_q;
	assign angular_speed = vang_q;

endmodule

FILE: bench/odometry_checker.sv
`timescale 1ns / 1ps
module odometry_checker import dd_odo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic signed [15:0] left_front_speed,
	input  logic signed [15:0] right_front_speed,
	input  logic signed [15:0] left_rear_speed,
	input  logic signed [15:0] right_rear_speed,
	input  logic [15:0]        elapsed_time,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [31:0] new_heading,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_x,
	input  logic signed [31:0] out_y,
	input  logic signed [31:0] out_heading,
	input  logic signed [31:0] linear_speed,
	input  logic signed [31:0] angular_speed,
	output int                 mismatches,
	output int                 pending,
	output int                 checked
);

	localparam longint ANG_PI      = 64'sd1686629713;
	localparam longint ANG_TWO_PI  = 64'sd3373259426;
	localparam longint ANG_HALF_PI = 64'sd843314857;
	localparam longint ROT_GAIN    = 64'sd652032874;
	localparam longint POS_MAX     = 64'sd2147483647;
	localparam longint POS_MIN     = -64'sd2147483648;
	localparam int     MAX_PRINTS  = 100;

	localparam longint ATAN_STEP [30] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
		64'sd33543516, 64'sd16775851, 64'sd8388437, 64'sd4194283, 64'sd2097149,
		64'sd1048576, 64'sd524288, 64'sd262144, 64'sd131072, 64'sd65536,
		64'sd32768, 64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048,
		64'sd1024, 64'sd512, 64'sd256, 64'sd128, 64'sd64,
		64'sd32, 64'sd16, 64'sd8, 64'sd4, 64'sd2
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] heading;
		logic signed [31:0] vlin;
		logic signed [31:0] vang;
	} pose_report_t;

	longint radius;
	longint scale;
	longint pos_x;
	longint pos_y;
	longint heading;
	pose_report_t expected_poses[$];

	function automatic longint fold_angle(input longint a);
		if (a > ANG_PI)
			return a - ANG_TWO_PI;
		if (a < -ANG_PI)
			return a + ANG_TWO_PI;
		return a;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	// angle Q3.29, cos/sin Q2.30
	function automatic void rotate(input longint angle, output longint c, output longint s);
		longint a;
		longint rx;
		longint ry;
		longint z;
		longint xs;
		longint ys;
		bit flip;
		int i;
		a = angle;
		flip = 1'b0;
		rx = ROT_GAIN;
		ry = 0;
		if (a > ANG_HALF_PI) begin
			a = a - ANG_PI;
			flip = 1'b1;
		end else if (a < -ANG_HALF_PI) begin
			a = a + ANG_PI;
			flip = 1'b1;
		end
		z = a * 2;
		for (i = 0; i < CORDIC_STEPS && i < 30; i++) begin
			xs = rx >>> i;
			ys = ry >>> i;
			if (z >= 0) begin
				rx = rx - ys;
				ry = ry + xs;
				z = z - ATAN_STEP[i];
			end else begin
				rx = rx + ys;
				ry = ry - xs;
				z = z + ATAN_STEP[i];
			end
		end
		c = flip ? -rx : rx;
		s = flip ? -ry : ry;
	endfunction

	function automatic pose_report_t integrate_wheels(
		input logic signed [15:0] lf,
		input logic signed [15:0] rf,
		input logic signed [15:0] lr,
		input logic signed [15:0] rr,
		input logic [15:0]        dt
	);
		longint sum4;
		longint diff4;
		longint dtl;
		longint vlin;
		longint vang;
		longint travel;
		longint turn;
		longint mid;
		longint c;
		longint s;
		pose_report_t res;
		dtl = longint'(dt);
		sum4 = longint'(rf) + longint'(rr) + longint'(lf) + longint'(lr);
		diff4 = longint'(rf) + longint'(rr) - longint'(lf) - longint'(lr);
		vlin = (radius * sum4) >>> 10;
		vang = (scale * diff4) >>> 5;
		travel = (radius * sum4 * dtl) >>> 26;
		turn = (scale * diff4 * dtl) >>> 8;
		if (turn > ANG_TWO_PI)
			turn = ANG_TWO_PI;
		else if (turn < -ANG_TWO_PI)
			turn = -ANG_TWO_PI;
		mid = fold_angle((turn >>> 1) + heading);
		rotate(mid, c, s);
		pos_x = clamp32(pos_x + ((c * travel) >>> 30));
		pos_y = clamp32(pos_y + ((s * travel) >>> 30));
		heading = fold_angle(heading + turn);
		res.x = pos_x[31:0];
		res.y = pos_y[31:0];
		res.heading = heading[31:0];
		res.vlin = vlin[31:0];
		res.vang = vang[31:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("ERROR %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		pose_report_t want;
		if (!arst_n) begin
			radius = longint'(RADIUS_RESET);
			scale = longint'(SCALE_RESET);
			pos_x = 0;
			pos_y = 0;
			heading = 0;
			expected_poses.delete();
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WHEEL_RADIUS)
					radius = longint'(cfg_data);
				else
					scale = longint'(cfg_data);
			end
			if (out_valid && !out_stall) begin
				if (expected_poses.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					want = expected_poses.pop_front();
					check_field("out_x", out_x, want.x);
					check_field("out_y", out_y, want.y);
					check_field("out_heading", out_heading, want.heading);
					check_field("linear_speed", linear_speed, want.vlin);
					check_field("angular_speed", angular_speed, want.vang);
				end
				checked <= checked + 1;
			end
			if (in_valid && !in_stall) begin
				if (command) begin
					pos_x = longint'(new_x);
					pos_y = longint'(new_y);
					heading = fold_angle(longint'(new_heading));
				end else begin
					expected_poses.push_back(integrate_wheels(left_front_speed,
						right_front_speed, left_rear_speed, right_rear_speed, elapsed_time));
				end
			end
			pending <= expected_poses.size();
		end
	end

endmodule

FILE: bench/diff_drive_odometry_unit_tb.sv
`timescale 1ns / 1ps
module diff_drive_odometry_unit_tb import dd_odo_pkg::*;;

	localparam int LIMIT       = 400000;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN       = CORDIC_STEPS + 30;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 160;

	localparam logic signed [15:0] SPD_MAX   = 16'sh7FFF;
	localparam logic signed [15:0] SPD_MIN   = 16'sh8000;
	localparam logic signed [31:0] HEAD_PI   = 32'sd1686629713;
	localparam logic signed [31:0] HEAD_HALF = 32'sd843314857;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic signed [15:0] left_front_speed;
	logic signed [15:0] right_front_speed;
	logic signed [15:0] left_rear_speed;
	logic signed [15:0] right_rear_speed;
	logic [15:0]        elapsed_time;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic signed [31:0] new_heading;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_heading;
	logic signed [31:0] linear_speed;
	logic signed [31:0] angular_speed;

	int mismatches;
	int pending;
	int checked;

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_req = 1'b0;
	int updates_sent = 0;
	int poses_sent = 0;
	int settings_used = 1;

	diff_drive_odometry_unit u_dut (.*);

	odometry_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT);
		$display("diff_drive_odometry_unit_tb failed");
		$finish;
	end

	// receiver side, with a single long hold-off on request
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= rx_idle && ($urandom_range(99) < 33);
			end
		end
	end

	function automatic logic signed [15:0] pick_speed();
		case ($urandom_range(9))
			0: return SPD_MAX;
			1: return SPD_MIN;
			2, 3, 4: return 16'($urandom_range(2047)) - 16'sd1024;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_dt();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(1310));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic signed [31:0] pick_position();
		case ($urandom_range(9))
			0: return 32'h7FFF_F000 | 32'($urandom_range(4095));
			1: return 32'h8000_0000 | 32'($urandom_range(4095));
			2, 3, 4: return 32'($urandom_range(20000000)) - 32'sd10000000;
			default: return 32'($urandom());
		endcase
	endfunction

	function automatic logic signed [31:0] pick_heading();
		case ($urandom_range(9))
			0: return HEAD_PI;
			1: return -HEAD_PI;
			2, 3: return 32'($urandom());
			default: return 32'(longint'($urandom_range(32'd3373259426)) - 64'sd1686629713);
		endcase
	endfunction

	task automatic offer_item(
		input logic               cmd,
		input logic signed [15:0] lf,
		input logic signed [15:0] rf,
		input logic signed [15:0] lr,
		input logic signed [15:0] rr,
		input logic [15:0]        dt,
		input logic signed [31:0] nx,
		input logic signed [31:0] ny,
		input logic signed [31:0] nh
	);
		if (tx_idle && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		left_front_speed <= lf;
		right_front_speed <= rf;
		left_rear_speed <= lr;
		right_rear_speed <= rr;
		elapsed_time <= dt;
		new_x <= nx;
		new_y <= ny;
		new_heading <= nh;
		do @(posedge clk); while (in_stall);
		if (cmd)
			poses_sent++;
		else
			updates_sent++;
	endtask

	task automatic drive_wheels(
		input logic signed [15:0] lf,
		input logic signed [15:0] rf,
		input logic signed [15:0] lr,
		input logic signed [15:0] rr,
		input logic [15:0]        dt
	);
		offer_item(1'b0, lf, rf, lr, rr, dt, 32'($urandom()), 32'($urandom()),
			32'($urandom()));
	endtask

	task automatic load_pose(
		input logic signed [31:0] nx,
		input logic signed [31:0] ny,
		input logic signed [31:0] nh
	);
		offer_item(1'b1, 16'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()), 16'($urandom()), nx, ny, nh);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_regs(input logic [15:0] radius, input logic [15:0] scale);
		cfg_we <= 1'b1;
		cfg_index <= REG_WHEEL_RADIUS;
		cfg_data <= radius;
		@(posedge clk);
		cfg_index <= REG_TURN_SCALE;
		cfg_data <= scale;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [15:0] radius;
		logic [15:0] scale;
		int phase;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WHEEL_RADIUS;
		cfg_data = '0;
		in_valid = 1'b0;
		command = 1'b0;
		left_front_speed = '0;
		right_front_speed = '0;
		left_rear_speed = '0;
		right_rear_speed = '0;
		elapsed_time = '0;
		new_x = '0;
		new_y = '0;
		new_heading = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		drive_wheels(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
		drive_wheels(16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'd655);
		drive_wheels(SPD_MAX, SPD_MAX, SPD_MAX, SPD_MAX, 16'hFFFF);
		drive_wheels(SPD_MIN, SPD_MIN, SPD_MIN, SPD_MIN, 16'hFFFF);
		drive_wheels(SPD_MIN, SPD_MAX, SPD_MIN, SPD_MAX, 16'hFFFF);
		drive_wheels(SPD_MAX, SPD_MIN, SPD_MAX, SPD_MIN, 16'hFFFF);
		drive_wheels(-16'sd256, 16'sd256, -16'sd256, 16'sd256, 16'd3000);
		drive_wheels(SPD_MAX, SPD_MAX, SPD_MAX, SPD_MAX, 16'd0);
		// position saturation both ways
		load_pose(32'sh7FFF_0000, 32'sd0, 32'sd0);
		drive_wheels(SPD_MAX, SPD_MAX, SPD_MAX, SPD_MAX, 16'hFFFF);
		load_pose(32'sh8001_0000, 32'sh7FFF_0000, HEAD_PI);
		drive_wheels(SPD_MAX, SPD_MAX, SPD_MAX, SPD_MAX, 16'hFFFF);
		load_pose(32'sd0, 32'sh8001_0000, -HEAD_HALF);
		drive_wheels(SPD_MAX, SPD_MAX, SPD_MAX, SPD_MAX, 16'hFFFF);
		// loaded heading outside +-pi
		load_pose(32'sd0, 32'sd0, 32'sh7FFF_FFFF);
		drive_wheels(16'sd512, 16'sd512, 16'sd512, 16'sd512, 16'd655);
		load_pose(32'sd0, 32'sd0, 32'sh8000_0000);
		drive_wheels(16'sd512, 16'sd512, 16'sd512, 16'sd512, 16'd655);
		// heading wrap through +-pi
		load_pose(32'sd0, 32'sd0, HEAD_PI - 32'sd1000);
		drive_wheels(-16'sd1024, 16'sd1024, -16'sd1024, 16'sd1024, 16'd2000);
		load_pose(32'sd0, 32'sd0, -HEAD_PI + 32'sd1000);
		drive_wheels(16'sd1024, -16'sd1024, 16'sd1024, -16'sd1024, 16'd2000);
		// midpoint just past +-pi/2
		load_pose(32'sd0, 32'sd0, HEAD_HALF + 32'sd1);
		drive_wheels(16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'd655);
		load_pose(32'sd0, 32'sd0, -HEAD_HALF - 32'sd1);
		drive_wheels(16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'd655);

		for (phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			repeat (DRAIN) @(posedge clk);
			case (phase)
				0: begin radius = 16'hFFFF; scale = 16'hFFFF; end
				1: begin radius = 16'h0000; scale = 16'h0000; end
				2: begin radius = RADIUS_RESET; scale = SCALE_RESET; end
				3: begin radius = 16'h0001; scale = 16'hFFFF; end
				4: begin radius = 16'hFFFF; scale = 16'h0000; end
				default: begin
					radius = 16'($urandom());
					scale = 16'($urandom());
				end
			endcase
			write_regs(radius, scale);
			tx_idle = (phase != 2);
			rx_idle = (phase != 2);
			if (phase == 3)
				hold_req = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 4 && n == PHASE_ITEMS / 2)
					wait_drained();
				if ($urandom_range(99) < 15)
					load_pose(pick_position(), pick_position(), pick_heading());
				else if ($urandom_range(9) == 0)
					drive_wheels(-pick_speed(), pick_speed(), -pick_speed(), pick_speed(),
						pick_dt());
				else
					drive_wheels(pick_speed(), pick_speed(), pick_speed(), pick_speed(),
						pick_dt());
			end
		end

		wait_drained();
		repeat (DRAIN) @(posedge clk);
		$display("ran %0d wheel updates and %0d pose loads over %0d register settings",
			updates_sent, poses_sent, settings_used);
		$display("checked %0d results, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("diff_drive_odometry_unit_tb passed");
		else
			$display("diff_drive_odometry_unit_tb failed");
		$finish;
	end

endmodule
